>>> hw/rtl/eg_pkg.sv
// Shared types and constants for the ElGamal symbol cipher.
// Used by the register block, the controller, the datapath and the top level.
// No dependencies.

package eg_pkg;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_GENERATOR   = 2'd0;
   localparam logic [1:0] REG_MODULUS     = 2'd1;
   localparam logic [1:0] REG_PRIVATE_KEY = 2'd2;

   // Register reset values.
   localparam int GENERATOR_RESET   = 2;
   localparam int MODULUS_RESET     = 65521;
   localparam int PRIVATE_KEY_RESET = 1;

   // Item operation codes.
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // Operand scanned bit by bit by the modular multiplier.
   localparam logic [2:0] SCAN_GEN = 3'd0;
   localparam logic [2:0] SCAN_A   = 3'd1;
   localparam logic [2:0] SCAN_KEY = 3'd2;
   localparam logic [2:0] SCAN_PW  = 3'd3;
   localparam logic [2:0] SCAN_M   = 3'd4;
   localparam logic [2:0] SCAN_B   = 3'd5;

   // Operand added at each step of the modular multiplier (always reduced).
   localparam logic [1:0] ADD_ONE = 2'd0;
   localparam logic [1:0] ADD_PW  = 2'd1;
   localparam logic [1:0] ADD_RED = 2'd2;
   localparam logic [1:0] ADD_Y   = 2'd3;

   // Destination of a finished product.
   localparam logic [2:0] DST_NONE = 3'd0;
   localparam logic [2:0] DST_RED  = 3'd1;
   localparam logic [2:0] DST_EXPD = 3'd2;
   localparam logic [2:0] DST_PW   = 3'd3;
   localparam logic [2:0] DST_FIN  = 3'd4;

   // Source of the exponent shift register.
   localparam logic EXP_SEL_KEY = 1'b0;
   localparam logic EXP_SEL_EPH = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       mul_start;
      logic [2:0] scan_sel;
      logic [1:0] add_sel;
      logic       mod_pm1;
      logic [2:0] dst;
      logic       pw_one;
      logic       exp_load;
      logic       exp_sel;
      logic       exp_shift;
      logic       y_load;
      logic       c1_load;
      logic       out_load;
   } eg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mul_busy;
      logic mul_done;
      logic exp_msb;
      logic op_decrypt;
      logic mod_small;
   } eg_sts_type;

endpackage

>>> hw/rtl/eg_req_if.sv
// Input channel of the ElGamal symbol cipher: valid/ready plus one item.
// Depends on nothing; the width parameter follows the modulus width.

interface eg_req_if #(parameter int W = 16);
   logic         valid;
   logic         ready;
   logic         operation;
   logic [W-1:0] plain_symbol;
   logic [W-1:0] ephemeral_key;
   logic [W-1:0] cipher_in_first;
   logic [W-1:0] cipher_in_second;

   modport source (
      output valid, operation, plain_symbol, ephemeral_key, cipher_in_first,
             cipher_in_second,
      input  ready
   );

   modport sink (
      input  valid, operation, plain_symbol, ephemeral_key, cipher_in_first,
             cipher_in_second,
      output ready
   );
endinterface

>>> hw/rtl/eg_rsp_if.sv
// Result channel of the ElGamal symbol cipher: valid/ready plus one result.
// Depends on nothing; the width parameter follows the modulus width.

interface eg_rsp_if #(parameter int W = 16);
   logic         valid;
   logic         ready;
   logic [W-1:0] ciphertext_first;
   logic [W-1:0] ciphertext_second;
   logic [W-1:0] recovered_symbol;

   modport source (
      output valid, ciphertext_first, ciphertext_second, recovered_symbol,
      input  ready
   );

   modport sink (
      input  valid, ciphertext_first, ciphertext_second, recovered_symbol,
      output ready
   );
endinterface

>>> hw/rtl/elgamal_symbol_cipher.sv
// ElGamal symbol cipher, top level.
// Depends on eg_pkg, eg_req_if, eg_rsp_if, eg_csr, eg_ctrl, eg_datapath, eg_mulmod.
//
// Usage: program generator, modulus and private key through the APB-style port
// (byte addresses 0, 4, 8) while the block is idle. Each transfer on req_ch
// carries one item: operation 0 encrypts plain_symbol with ephemeral_key and
// returns (g^k mod p, y^k * m mod p) with y = g^x mod p; operation 1 decrypts
// (cipher_in_first, cipher_in_second) and returns the symbol. Exactly one result
// per item leaves on rsp_ch; unused result fields are zero, and all fields are
// zero for a modulus below two.
// All arithmetic runs on one bit-serial modular multiplier, one bit per cycle.
// An exponentiation takes MOD_WIDTH squarings plus one product per set exponent
// bit. One item is in work at a time; req_ch.ready is high while the block
// waits for an item.
// Results sit in an output register, so the next item is taken while a result
// waits; a stalled receiver holds the finished next result until the register
// frees. Reset is synchronous: registers return to g=2, p=65521, x=1 and no
// result is offered on rsp_ch.

module elgamal_symbol_cipher #(
   parameter int MOD_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   eg_req_if.sink                         req_ch,
   eg_rsp_if.source                       rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [eg_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [eg_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [eg_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                           pready
);

   logic [MOD_WIDTH-1:0] cfg_generator;
   logic [MOD_WIDTH-1:0] cfg_modulus;
   logic [MOD_WIDTH-1:0] cfg_private_key;
   eg_pkg::eg_cmd_type   cmd;
   eg_pkg::eg_sts_type   sts;

   assign pready = 1'b1;

   // Configuration registers.
   eg_csr #(.W(MOD_WIDTH)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .generator   (cfg_generator),
      .modulus     (cfg_modulus),
      .private_key (cfg_private_key)
   );

   // Sequencing and handshakes.
   eg_ctrl #(.W(MOD_WIDTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Arithmetic and storage.
   eg_datapath #(.W(MOD_WIDTH)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .operation         (req_ch.operation),
      .plain_symbol      (req_ch.plain_symbol),
      .ephemeral_key     (req_ch.ephemeral_key),
      .cipher_in_first   (req_ch.cipher_in_first),
      .cipher_in_second  (req_ch.cipher_in_second),
      .generator         (cfg_generator),
      .modulus           (cfg_modulus),
      .private_key       (cfg_private_key),
      .ciphertext_first  (rsp_ch.ciphertext_first),
      .ciphertext_second (rsp_ch.ciphertext_second),
      .recovered_symbol  (rsp_ch.recovered_symbol)
   );

endmodule

>>> hw/rtl/eg_csr.sv
// Configuration registers (generator, modulus, private key) behind an APB-style port.
// Depends on eg_pkg for the register map and reset values.

module eg_csr #(
   parameter int W = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [eg_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [eg_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [eg_pkg::CSR_DATA_W-1:0]  prdata,
   output logic [W-1:0]                   generator,
   output logic [W-1:0]                   modulus,
   output logic [W-1:0]                   private_key
);

   logic [W-1:0] gen_ff, gen_in;
   logic [W-1:0] mod_ff, mod_in;
   logic [W-1:0] key_ff, key_in;
   logic         wr_en;
   logic [1:0]   reg_idx;

   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   // Register writes complete in the access phase of a transfer.
   always_comb begin
      gen_in = gen_ff;
      mod_in = mod_ff;
      key_in = key_ff;
      if (wr_en) begin
         unique case (reg_idx)
            eg_pkg::REG_GENERATOR:   gen_in = pwdata[W-1:0];
            eg_pkg::REG_MODULUS:     mod_in = pwdata[W-1:0];
            eg_pkg::REG_PRIVATE_KEY: key_in = pwdata[W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= W'(eg_pkg::GENERATOR_RESET);
         mod_ff <= W'(eg_pkg::MODULUS_RESET);
         key_ff <= W'(eg_pkg::PRIVATE_KEY_RESET);
      end else begin
         gen_ff <= gen_in;
         mod_ff <= mod_in;
         key_ff <= key_in;
      end
   end

   // Read-back decode.
   always_comb begin
      unique case (reg_idx)
         eg_pkg::REG_GENERATOR:   prdata = eg_pkg::CSR_DATA_W'(gen_ff);
         eg_pkg::REG_MODULUS:     prdata = eg_pkg::CSR_DATA_W'(mod_ff);
         eg_pkg::REG_PRIVATE_KEY: prdata = eg_pkg::CSR_DATA_W'(key_ff);
         default:                 prdata = '0;
      endcase
   end

   assign generator   = gen_ff;
   assign modulus     = mod_ff;
   assign private_key = key_ff;

endmodule

>>> hw/rtl/eg_mulmod.sv
// Bit-serial modular multiplier: scans one operand MSB first, one bit per cycle.
// Standalone unit, used by eg_datapath; no package dependencies.

module eg_mulmod #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] op_scan,
   input  logic [W-1:0] op_add,
   input  logic [W-1:0] op_mod,
   output logic         busy,
   output logic         done,
   output logic [W-1:0] result
);

   localparam int CW = $clog2(W);
   localparam logic [CW-1:0] LAST = CW'(W - 1);

   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  scan_ff, scan_in;
   logic [W-1:0]  add_ff, add_in;
   logic [W-1:0]  n_ff, n_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [W+1:0]  sum;
   logic [W+1:0]  n1;
   logic [W+1:0]  n2;
   logic [W+1:0]  red;

   // One Horner step: acc = 2*acc + bit*add, brought back below n.
   // Both acc and add are below n, so the sum is below 3n.
   always_comb begin
      sum = {1'b0, acc_ff, 1'b0} + (scan_ff[W-1] ? {2'b00, add_ff} : '0);
      n1  = {2'b00, n_ff};
      n2  = {1'b0, n_ff, 1'b0};
      if (sum >= n2) begin
         red = sum - n2;
      end else if (sum >= n1) begin
         red = sum - n1;
      end else begin
         red = sum;
      end
   end

   // Operand load on start, then W steps.
   always_comb begin
      acc_in  = acc_ff;
      scan_in = scan_ff;
      add_in  = add_ff;
      n_in    = n_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         scan_in = op_scan;
         add_in  = op_add;
         n_in    = op_mod;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = red[W-1:0];
         scan_in = {scan_ff[W-2:0], 1'b0};
         cnt_in  = cnt_ff + CW'(1);
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      scan_ff <= scan_in;
      add_ff  <= add_in;
      n_ff    <= n_in;
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = acc_ff;

   // The running product stays reduced while the unit works.
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (acc_ff < n_ff))
      else $error("modular multiplier accumulator not below modulus");

   // Completion follows a busy interval.
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("multiplier done without a preceding step");

endmodule

>>> hw/rtl/eg_datapath.sv
// Datapath of the ElGamal symbol cipher: item registers, exponent and power
// registers, operand selection, result registers. Instantiates eg_mulmod; uses eg_pkg.

module eg_datapath #(
   parameter int W = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  eg_pkg::eg_cmd_type cmd,
   output eg_pkg::eg_sts_type sts,
   input  logic               operation,
   input  logic [W-1:0]       plain_symbol,
   input  logic [W-1:0]       ephemeral_key,
   input  logic [W-1:0]       cipher_in_first,
   input  logic [W-1:0]       cipher_in_second,
   input  logic [W-1:0]       generator,
   input  logic [W-1:0]       modulus,
   input  logic [W-1:0]       private_key,
   output logic [W-1:0]       ciphertext_first,
   output logic [W-1:0]       ciphertext_second,
   output logic [W-1:0]       recovered_symbol
);

   logic         op_ff, op_in;
   logic [W-1:0] m_ff, m_in;
   logic [W-1:0] k_ff, k_in;
   logic [W-1:0] a_ff, a_in;
   logic [W-1:0] b_ff, b_in;
   logic [W-1:0] red_ff, red_in;
   logic [W-1:0] y_ff, y_in;
   logic [W-1:0] c1_ff, c1_in;
   logic [W-1:0] pw_ff, pw_in;
   logic [W-1:0] exp_ff, exp_in;
   logic [W-1:0] fin_ff, fin_in;
   logic [W-1:0] out1_ff, out1_in;
   logic [W-1:0] out2_ff, out2_in;
   logic [W-1:0] out3_ff, out3_in;

   logic [W-1:0] pm1;
   logic [W-1:0] n_sel;
   logic [W-1:0] one_red;
   logic [W-1:0] scan_op;
   logic [W-1:0] add_op;
   logic         mul_busy;
   logic         mul_done;
   logic [W-1:0] mul_res;
   logic         mod_small;
   logic [W-1:0] recovered_symbol_w;

   assign pm1       = modulus - W'(1);
   assign n_sel     = cmd.mod_pm1 ? pm1 : modulus;
   assign one_red   = (n_sel == W'(1)) ? '0 : W'(1);
   assign mod_small = (modulus < W'(2));

   // Operand selection for the multiplier.
   always_comb begin
      case (cmd.scan_sel)
         eg_pkg::SCAN_GEN: scan_op = generator;
         eg_pkg::SCAN_A:   scan_op = a_ff;
         eg_pkg::SCAN_KEY: scan_op = private_key;
         eg_pkg::SCAN_PW:  scan_op = pw_ff;
         eg_pkg::SCAN_M:   scan_op = m_ff;
         eg_pkg::SCAN_B:   scan_op = b_ff;
         default:          scan_op = '0;
      endcase
      case (cmd.add_sel)
         eg_pkg::ADD_ONE: add_op = one_red;
         eg_pkg::ADD_PW:  add_op = pw_ff;
         eg_pkg::ADD_RED: add_op = red_ff;
         eg_pkg::ADD_Y:   add_op = y_ff;
         default:         add_op = '0;
      endcase
   end

   eg_mulmod #(.W(W)) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .op_scan (scan_op),
      .op_add  (add_op),
      .op_mod  (n_sel),
      .busy    (mul_busy),
      .done    (mul_done),
      .result  (mul_res)
   );

   // Item capture and working registers.
   always_comb begin
      op_in  = op_ff;
      m_in   = m_ff;
      k_in   = k_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      red_in = red_ff;
      y_in   = y_ff;
      c1_in  = c1_ff;
      pw_in  = pw_ff;
      exp_in = exp_ff;
      fin_in = fin_ff;
      if (cmd.capture) begin
         op_in = operation;
         m_in  = plain_symbol;
         k_in  = ephemeral_key;
         a_in  = cipher_in_first;
         b_in  = cipher_in_second;
      end
      if (cmd.pw_one) begin
         pw_in = W'(1);
      end
      if (cmd.exp_load) begin
         exp_in = (cmd.exp_sel == eg_pkg::EXP_SEL_EPH) ? k_ff : private_key;
      end
      if (cmd.exp_shift) begin
         exp_in = {exp_ff[W-2:0], 1'b0};
      end
      if (cmd.y_load) begin
         y_in = pw_ff;
      end
      if (cmd.c1_load) begin
         c1_in = pw_ff;
      end
      // Product write-back.
      case (cmd.dst)
         eg_pkg::DST_RED:  red_in = mul_res;
         eg_pkg::DST_EXPD: exp_in = pm1 - mul_res;
         eg_pkg::DST_PW:   pw_in  = mul_res;
         eg_pkg::DST_FIN:  fin_in = mul_res;
         default: ;
      endcase
   end

   // Result register; it holds until the next load.
   always_comb begin
      out1_in = out1_ff;
      out2_in = out2_ff;
      out3_in = out3_ff;
      if (cmd.out_load) begin
         out1_in = '0;
         out2_in = '0;
         out3_in = '0;
         if (!mod_small) begin
            if (op_ff == eg_pkg::OP_DECRYPT) begin
               out3_in = fin_ff;
            end else begin
               out1_in = c1_ff;
               out2_in = fin_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      m_ff    <= m_in;
      k_ff    <= k_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      red_ff  <= red_in;
      y_ff    <= y_in;
      c1_ff   <= c1_in;
      pw_ff   <= pw_in;
      exp_ff  <= exp_in;
      fin_ff  <= fin_in;
      out1_ff <= out1_in;
      out2_ff <= out2_in;
      out3_ff <= out3_in;
   end

   assign sts.mul_busy   = mul_busy;
   assign sts.mul_done   = mul_done;
   assign sts.exp_msb    = exp_ff[W-1];
   assign sts.op_decrypt = (op_ff == eg_pkg::OP_DECRYPT);
   assign sts.mod_small  = mod_small;

   assign ciphertext_first  = out1_ff;
   assign ciphertext_second = out2_ff;
   assign recovered_symbol  = recovered_symbol_w;

   assign recovered_symbol_w = out3_ff;

endmodule

>>> hw/rtl/eg_ctrl.sv
// Controller of the ElGamal symbol cipher: sequences reductions, square-and-multiply
// exponentiations and the final product, and owns both handshakes. Uses eg_pkg.

module eg_ctrl #(
   parameter int W = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  eg_pkg::eg_sts_type sts,
   output eg_pkg::eg_cmd_type cmd
);

   localparam int CW = $clog2(W);
   localparam logic [CW-1:0] LAST = CW'(W - 1);

   // State codes.
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CHECK    = 4'd1;
   localparam logic [3:0] S_RED_G    = 4'd2;
   localparam logic [3:0] S_RED_A    = 4'd3;
   localparam logic [3:0] S_RED_X    = 4'd4;
   localparam logic [3:0] S_EXP_INIT = 4'd5;
   localparam logic [3:0] S_SQ       = 4'd6;
   localparam logic [3:0] S_MB       = 4'd7;
   localparam logic [3:0] S_EXP_NEXT = 4'd8;
   localparam logic [3:0] S_FIN      = 4'd9;
   localparam logic [3:0] S_OUT      = 4'd10;

   // Exponentiation phases: y = g^x, g^k, y^k, a^e.
   localparam logic [1:0] PH_Y  = 2'd0;
   localparam logic [1:0] PH_C1 = 2'd1;
   localparam logic [1:0] PH_T  = 2'd2;
   localparam logic [1:0] PH_P  = 2'd3;

   logic [3:0]    state_ff, state_in;
   logic          started_ff, started_in;
   logic [1:0]    phase_ff, phase_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          out_valid_ff, out_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      started_in   = started_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end

         S_CHECK: begin
            if (sts.mod_small) begin
               state_in = S_OUT;
            end else if (sts.op_decrypt) begin
               state_in = S_RED_A;
            end else begin
               state_in = S_RED_G;
            end
         end

         // g mod p
         S_RED_G: begin
            cmd.scan_sel = eg_pkg::SCAN_GEN;
            cmd.add_sel  = eg_pkg::ADD_ONE;
            if (!started_ff) begin
               cmd.mul_start = 1'b1;
               started_in    = 1'b1;
            end else if (sts.mul_done) begin
               cmd.dst    = eg_pkg::DST_RED;
               started_in = 1'b0;
               phase_in   = PH_Y;
               state_in   = S_EXP_INIT;
            end
         end

         // a mod p
         S_RED_A: begin
            cmd.scan_sel = eg_pkg::SCAN_A;
            cmd.add_sel  = eg_pkg::ADD_ONE;
            if (!started_ff) begin
               cmd.mul_start = 1'b1;
               started_in    = 1'b1;
            end else if (sts.mul_done) begin
               cmd.dst    = eg_pkg::DST_RED;
               started_in = 1'b0;
               state_in   = S_RED_X;
            end
         end

         // x mod (p-1); the datapath stores p-1 minus it as the exponent.
         S_RED_X: begin
            cmd.scan_sel = eg_pkg::SCAN_KEY;
            cmd.add_sel  = eg_pkg::ADD_ONE;
            cmd.mod_pm1  = 1'b1;
            if (!started_ff) begin
               cmd.mul_start = 1'b1;
               started_in    = 1'b1;
            end else if (sts.mul_done) begin
               cmd.dst    = eg_pkg::DST_EXPD;
               started_in = 1'b0;
               phase_in   = PH_P;
               state_in   = S_EXP_INIT;
            end
         end

         S_EXP_INIT: begin
            cmd.pw_one   = 1'b1;
            cmd.exp_load = (phase_ff != PH_P);
            cmd.exp_sel  = (phase_ff == PH_Y) ? eg_pkg::EXP_SEL_KEY : eg_pkg::EXP_SEL_EPH;
            cnt_in       = '0;
            state_in     = S_SQ;
         end

         // Square for every exponent bit.
         S_SQ: begin
            cmd.scan_sel = eg_pkg::SCAN_PW;
            cmd.add_sel  = eg_pkg::ADD_PW;
            if (!started_ff) begin
               cmd.mul_start = 1'b1;
               started_in    = 1'b1;
            end else if (sts.mul_done) begin
               cmd.dst    = eg_pkg::DST_PW;
               started_in = 1'b0;
               state_in   = sts.exp_msb ? S_MB : S_EXP_NEXT;
            end
         end

         // Multiply by the base where the exponent bit is set.
         S_MB: begin
            cmd.scan_sel = eg_pkg::SCAN_PW;
            cmd.add_sel  = (phase_ff == PH_T) ? eg_pkg::ADD_Y : eg_pkg::ADD_RED;
            if (!started_ff) begin
               cmd.mul_start = 1'b1;
               started_in    = 1'b1;
            end else if (sts.mul_done) begin
               cmd.dst    = eg_pkg::DST_PW;
               started_in = 1'b0;
               state_in   = S_EXP_NEXT;
            end
         end

         S_EXP_NEXT: begin
            cmd.exp_shift = 1'b1;
            if (cnt_ff == LAST) begin
               case (phase_ff)
                  PH_Y: begin
                     cmd.y_load = 1'b1;
                     phase_in   = PH_C1;
                     state_in   = S_EXP_INIT;
                  end
                  PH_C1: begin
                     cmd.c1_load = 1'b1;
                     phase_in    = PH_T;
                     state_in    = S_EXP_INIT;
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = S_SQ;
            end
         end

         // m * y^k on encrypt, b * a^e on decrypt.
         S_FIN: begin
            cmd.scan_sel = sts.op_decrypt ? eg_pkg::SCAN_B : eg_pkg::SCAN_M;
            cmd.add_sel  = eg_pkg::ADD_PW;
            if (!started_ff) begin
               cmd.mul_start = 1'b1;
               started_in    = 1'b1;
            end else if (sts.mul_done) begin
               cmd.dst    = eg_pkg::DST_FIN;
               started_in = 1'b0;
               state_in   = S_OUT;
            end
         end

         // Hand the result to the output register once it is free.
         S_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in   = S_IDLE;
            started_in = 1'b0;
         end
      endcase

      // Output valid: set on load, cleared by a transfer.
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         started_ff   <= 1'b0;
         phase_ff     <= PH_Y;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

   // A product is never started while the multiplier is still working.
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> !sts.mul_busy)
      else $error("multiplier started while busy");

   // A finished product arrives only for a product this controller started.
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      sts.mul_done |-> started_ff)
      else $error("unexpected multiplier completion");

   // A loaded result is offered in the following cycle.
   a_load_offers: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("loaded result not offered");

endmodule
